// ===== rtl/rpmc_pkg.sv =====
// Shared types and constants for the red pixel mask and centroid block.
package rpmc_pkg;

    // Field widths fixed by the pixel and result formats
    localparam int PIX_W      = 8;
    localparam int RATIO_W    = 8;
    localparam int SIZE_W     = 11;
    localparam int COUNT_W    = 21;
    localparam int SUM_W      = 30;
    localparam int CENT_W     = 10;

    // Threshold compare: (red+1) >= (ratio+1) * (blue+green+2)
    localparam int NUM_W      = PIX_W + 1;
    localparam int DEN_W      = PIX_W + 2;
    localparam int PROD_W     = NUM_W + DEN_W;

    // Restoring divider for the centroid
    localparam int REM_W      = COUNT_W + 1;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Queue between classifier and divider
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [RATIO_W-1:0] RATIO_RST = 8'd10;
    localparam logic [SIZE_W-1:0]  COLS_RST  = 11'd640;
    localparam logic [SIZE_W-1:0]  ROWS_RST  = 11'd480;

    typedef enum logic [1:0] {
        REG_RED_RATIO  = 2'd0,
        REG_FRAME_COLS = 2'd1,
        REG_FRAME_ROWS = 2'd2
    } reg_idx_t;

    // Live configuration seen by the classifier
    typedef struct packed {
        logic [RATIO_W-1:0] red_ratio;
        logic [SIZE_W-1:0]  frame_cols;
        logic [SIZE_W-1:0]  frame_rows;
    } cfg_t;

    // One classified pixel with the frame totals that include it
    typedef struct packed {
        logic               mask;
        logic               frame_end;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
    } item_t;

endpackage

// ===== rtl/rpmc_fifo.sv =====
// Small register queue between the pixel classifier and the centroid divider.
module rpmc_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rpmc_pkg::item_t     push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output rpmc_pkg::item_t     pop_data
);

    rpmc_pkg::item_t                      mem_reg [rpmc_pkg::FIFO_DEPTH];
    logic [rpmc_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [rpmc_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [rpmc_pkg::FIFO_CNT_W-1:0]      count_reg;

    assign full      = (count_reg == rpmc_pkg::FIFO_CNT_W'(rpmc_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/rpmc_front.sv =====
// Pixel classifier: red threshold, raster position tracking and frame sums.
module rpmc_front
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rpmc_pkg::cfg_t                cfg,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [rpmc_pkg::PIX_W-1:0]    blue,
    input  logic [rpmc_pkg::PIX_W-1:0]    green,
    input  logic [rpmc_pkg::PIX_W-1:0]    red,
    output logic                          push,
    output rpmc_pkg::item_t               push_data,
    input  logic                          fifo_full
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CSZ_W  = (COL_W + 1 > rpmc_pkg::SIZE_W) ? COL_W + 1 : rpmc_pkg::SIZE_W;
    localparam int RSZ_W  = (ROW_W + 1 > rpmc_pkg::SIZE_W) ? ROW_W + 1 : rpmc_pkg::SIZE_W;

    logic [COL_W-1:0]              col_pos_reg;
    logic [ROW_W-1:0]              row_pos_reg;
    logic [rpmc_pkg::COUNT_W-1:0]  total_reg;
    logic [rpmc_pkg::SUM_W-1:0]    col_sum_reg;
    logic [rpmc_pkg::SUM_W-1:0]    row_sum_reg;

    logic [CSZ_W-1:0]              cols_cfg;
    logic [CSZ_W-1:0]              cols_eff;
    logic [RSZ_W-1:0]              rows_cfg;
    logic [RSZ_W-1:0]              rows_eff;
    logic                          row_last;
    logic                          frame_last;

    logic [rpmc_pkg::NUM_W-1:0]    num;
    logic [rpmc_pkg::NUM_W-1:0]    thr;
    logic [rpmc_pkg::DEN_W-1:0]    den;
    logic [rpmc_pkg::PROD_W-1:0]   prod;
    logic                          is_red;

    logic [rpmc_pkg::COUNT_W-1:0]  total_next;
    logic [rpmc_pkg::SUM_W-1:0]    col_sum_next;
    logic [rpmc_pkg::SUM_W-1:0]    row_sum_next;

    assign pix_stall = fifo_full;
    assign push      = pix_valid && !pix_stall;

    // Clamp frame size: zero counts as one, above the maximum as the maximum
    always_comb
    begin
        cols_cfg = CSZ_W'(cfg.frame_cols);
        rows_cfg = RSZ_W'(cfg.frame_rows);
        if (cols_cfg == '0)
            cols_eff = CSZ_W'(1);
        else if (cols_cfg > CSZ_W'(MAX_COLS))
            cols_eff = CSZ_W'(MAX_COLS);
        else
            cols_eff = cols_cfg;
        if (rows_cfg == '0)
            rows_eff = RSZ_W'(1);
        else if (rows_cfg > RSZ_W'(MAX_ROWS))
            rows_eff = RSZ_W'(MAX_ROWS);
        else
            rows_eff = rows_cfg;
    end

    // Row and frame end detection
    assign row_last   = (CSZ_W'(col_pos_reg) + CSZ_W'(1)) >= cols_eff;
    assign frame_last = row_last && ((RSZ_W'(row_pos_reg) + RSZ_W'(1)) >= rows_eff);

    // Quotient floor((r+1)/(b+g+2)) > ratio, done as a multiply and compare
    assign num    = rpmc_pkg::NUM_W'(red) + rpmc_pkg::NUM_W'(1);
    assign thr    = rpmc_pkg::NUM_W'(cfg.red_ratio) + rpmc_pkg::NUM_W'(1);
    assign den    = rpmc_pkg::DEN_W'(blue) + rpmc_pkg::DEN_W'(green) + rpmc_pkg::DEN_W'(2);
    assign prod   = rpmc_pkg::PROD_W'(thr) * rpmc_pkg::PROD_W'(den);
    assign is_red = rpmc_pkg::PROD_W'(num) >= prod;

    // Running totals including this pixel
    always_comb
    begin
        total_next   = total_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        if (is_red)
        begin
            total_next   = total_reg + 1'b1;
            col_sum_next = col_sum_reg + rpmc_pkg::SUM_W'(col_pos_reg);
            row_sum_next = row_sum_reg + rpmc_pkg::SUM_W'(row_pos_reg);
        end
    end

    always_comb
    begin
        push_data.mask      = is_red;
        push_data.frame_end = frame_last;
        push_data.count     = total_next;
        push_data.col_sum   = col_sum_next;
        push_data.row_sum   = row_sum_next;
    end

    // Position and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            total_reg   <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end
        else if (push)
        begin
            if (frame_last)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= '0;
                total_reg   <= '0;
                col_sum_reg <= '0;
                row_sum_reg <= '0;
            end
            else
            begin
                total_reg   <= total_next;
                col_sum_reg <= col_sum_next;
                row_sum_reg <= row_sum_next;
                if (row_last)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= row_pos_reg + 1'b1;
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/rpmc_back.sv =====
// Result stage: centroid divider and output register.
module rpmc_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fifo_valid,
    input  rpmc_pkg::item_t                 fifo_data,
    output logic                            pop,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic                            mask_white,
    output logic                            frame_end,
    output logic                            found,
    output logic [rpmc_pkg::COUNT_W-1:0]    red_count,
    output logic [rpmc_pkg::CENT_W-1:0]     centroid_col,
    output logic [rpmc_pkg::CENT_W-1:0]     centroid_row
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                          state_reg;
    logic [rpmc_pkg::STEP_W-1:0]     step_reg;
    logic [rpmc_pkg::COUNT_W-1:0]    divisor_reg;
    logic [rpmc_pkg::SUM_W-1:0]      quo_col_reg;
    logic [rpmc_pkg::SUM_W-1:0]      quo_row_reg;
    logic [rpmc_pkg::REM_W-1:0]      rem_col_reg;
    logic [rpmc_pkg::REM_W-1:0]      rem_row_reg;
    logic                            mask_hold_reg;

    logic                            res_valid_reg;
    logic                            mask_white_reg;
    logic                            frame_end_reg;
    logic                            found_reg;
    logic [rpmc_pkg::COUNT_W-1:0]    red_count_reg;
    logic [rpmc_pkg::CENT_W-1:0]     centroid_col_reg;
    logic [rpmc_pkg::CENT_W-1:0]     centroid_row_reg;

    logic                            out_free;
    logic                            need_div;
    logic                            load_out;
    logic [rpmc_pkg::REM_W-1:0]      rem_col_next;
    logic [rpmc_pkg::REM_W-1:0]      rem_row_next;
    logic [rpmc_pkg::SUM_W-1:0]      quo_col_next;
    logic [rpmc_pkg::SUM_W-1:0]      quo_row_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [rpmc_pkg::REM_W+rpmc_pkg::SUM_W-1:0] div_step
    (
        input logic [rpmc_pkg::REM_W-1:0]   rem,
        input logic [rpmc_pkg::SUM_W-1:0]   quo,
        input logic [rpmc_pkg::COUNT_W-1:0] divisor
    );
        logic [rpmc_pkg::REM_W-1:0] shifted;
        logic [rpmc_pkg::REM_W-1:0] dext;
        logic                       fits;
        shifted = {rem[rpmc_pkg::REM_W-2:0], quo[rpmc_pkg::SUM_W-1]};
        dext    = rpmc_pkg::REM_W'(divisor);
        fits    = shifted >= dext;
        return {(fits ? shifted - dext : shifted), quo[rpmc_pkg::SUM_W-2:0], fits};
    endfunction

    assign {rem_col_next, quo_col_next} = div_step(rem_col_reg, quo_col_reg, divisor_reg);
    assign {rem_row_next, quo_row_next} = div_step(rem_row_reg, quo_row_reg, divisor_reg);

    assign out_free = !res_valid_reg || !res_stall;
    assign need_div = fifo_data.frame_end && (fifo_data.count != '0);

    // Output register takes a new transaction this cycle
    assign load_out = ((state_reg == ST_IDLE) && fifo_valid && !need_div && out_free)
                   || ((state_reg == ST_HOLD) && out_free);

    // Dequeue when idle: divide entries go straight in, others need a free output
    always_comb
    begin
        pop = 1'b0;
        if (state_reg == ST_IDLE && fifo_valid)
        begin
            pop = need_div || out_free;
        end
    end

    // Sequencer, divider and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            divisor_reg      <= '0;
            quo_col_reg      <= '0;
            quo_row_reg      <= '0;
            rem_col_reg      <= '0;
            rem_row_reg      <= '0;
            mask_hold_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
            mask_white_reg   <= 1'b0;
            frame_end_reg    <= 1'b0;
            found_reg        <= 1'b0;
            red_count_reg    <= '0;
            centroid_col_reg <= '0;
            centroid_row_reg <= '0;
        end
        else
        begin
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (fifo_valid && need_div)
                    begin
                        divisor_reg   <= fifo_data.count;
                        quo_col_reg   <= fifo_data.col_sum;
                        quo_row_reg   <= fifo_data.row_sum;
                        rem_col_reg   <= '0;
                        rem_row_reg   <= '0;
                        mask_hold_reg <= fifo_data.mask;
                        step_reg      <= '0;
                        state_reg     <= ST_DIV;
                    end
                    else if (fifo_valid && out_free)
                    begin
                        mask_white_reg   <= fifo_data.mask;
                        frame_end_reg    <= fifo_data.frame_end;
                        found_reg        <= 1'b0;
                        red_count_reg    <= '0;
                        centroid_col_reg <= '0;
                        centroid_row_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    rem_col_reg <= rem_col_next;
                    rem_row_reg <= rem_row_next;
                    quo_col_reg <= quo_col_next;
                    quo_row_reg <= quo_row_next;
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == rpmc_pkg::STEP_W'(rpmc_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        mask_white_reg   <= mask_hold_reg;
                        frame_end_reg    <= 1'b1;
                        found_reg        <= 1'b1;
                        red_count_reg    <= divisor_reg;
                        centroid_col_reg <= quo_col_reg[rpmc_pkg::CENT_W-1:0];
                        centroid_row_reg <= quo_row_reg[rpmc_pkg::CENT_W-1:0];
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid    = res_valid_reg;
    assign mask_white   = mask_white_reg;
    assign frame_end    = frame_end_reg;
    assign found        = found_reg;
    assign red_count    = red_count_reg;
    assign centroid_col = centroid_col_reg;
    assign centroid_row = centroid_row_reg;

endmodule

// ===== rtl/red_pixel_mask_centroid.sv =====
// Red pixel mask and centroid: register file and top-level wiring.
// Path: a pixel's result passes through the queue and then the output register before it is offered;
// the last pixel of a frame with red pixels also waits for the 30-step centroid divider.
// Throughput: one pixel per cycle while pix_stall is low; such a frame end holds the result stage
// while it divides, the four-entry queue takes four more pixels and then the input stalls until
// an entry is popped.
// Reset (rst_n, async low): positions and sums clear, registers load 10 / 640 / 480.
module red_pixel_mask_centroid
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rpmc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rpmc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rpmc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Pixel channel
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  logic [rpmc_pkg::PIX_W-1:0]          blue,
    input  logic [rpmc_pkg::PIX_W-1:0]          green,
    input  logic [rpmc_pkg::PIX_W-1:0]          red,
    // Result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic                                mask_white,
    output logic                                frame_end,
    output logic                                found,
    output logic [rpmc_pkg::COUNT_W-1:0]        red_count,
    output logic [rpmc_pkg::CENT_W-1:0]         centroid_col,
    output logic [rpmc_pkg::CENT_W-1:0]         centroid_row
);

    logic [rpmc_pkg::RATIO_W-1:0]   red_ratio_reg;
    logic [rpmc_pkg::SIZE_W-1:0]    frame_cols_reg;
    logic [rpmc_pkg::SIZE_W-1:0]    frame_rows_reg;
    rpmc_pkg::reg_idx_t             reg_idx;
    logic                           cfg_wr;
    rpmc_pkg::cfg_t                 cfg;

    logic                           push;
    rpmc_pkg::item_t                push_data;
    logic                           fifo_full;
    logic                           pop;
    logic                           fifo_valid;
    rpmc_pkg::item_t                fifo_data;

    assign pready  = 1'b1;
    assign reg_idx = rpmc_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_ratio_reg  <= rpmc_pkg::RATIO_RST;
            frame_cols_reg <= rpmc_pkg::COLS_RST;
            frame_rows_reg <= rpmc_pkg::ROWS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                rpmc_pkg::REG_RED_RATIO:  red_ratio_reg  <= pwdata[rpmc_pkg::RATIO_W-1:0];
                rpmc_pkg::REG_FRAME_COLS: frame_cols_reg <= pwdata[rpmc_pkg::SIZE_W-1:0];
                rpmc_pkg::REG_FRAME_ROWS: frame_rows_reg <= pwdata[rpmc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_idx)
            rpmc_pkg::REG_RED_RATIO:  prdata = rpmc_pkg::APB_DATA_W'(red_ratio_reg);
            rpmc_pkg::REG_FRAME_COLS: prdata = rpmc_pkg::APB_DATA_W'(frame_cols_reg);
            rpmc_pkg::REG_FRAME_ROWS: prdata = rpmc_pkg::APB_DATA_W'(frame_rows_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.red_ratio  = red_ratio_reg;
        cfg.frame_cols = frame_cols_reg;
        cfg.frame_rows = frame_rows_reg;
    end

    rpmc_front
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    rpmc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_valid),
        .pop_data  (fifo_data)
    );

    rpmc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_valid   (fifo_valid),
        .fifo_data    (fifo_data),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .mask_white   (mask_white),
        .frame_end    (frame_end),
        .found        (found),
        .red_count    (red_count),
        .centroid_col (centroid_col),
        .centroid_row (centroid_row)
    );

endmodule

// ===== rtl/rpmc_checker.sv =====
// Port-level assertions for the red pixel mask and centroid block, with bind.
module rpmc_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  logic                              mask_white,
    input  logic                              frame_end,
    input  logic                              found,
    input  logic [rpmc_pkg::COUNT_W-1:0]      red_count,
    input  logic [rpmc_pkg::CENT_W-1:0]       centroid_col,
    input  logic [rpmc_pkg::CENT_W-1:0]       centroid_row
);

    // A stalled result transaction holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(mask_white) && $stable(frame_end)
            && $stable(found) && $stable(red_count) && $stable(centroid_col)
            && $stable(centroid_row))
        else $error("result payload changed while stalled");

    // Frame statistics appear only on the last pixel of a frame
    a_mid_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_end |-> !found && red_count == '0
            && centroid_col == '0 && centroid_row == '0)
        else $error("statistics reported mid-frame");

    // found tracks a nonzero red count
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> found == (red_count != '0))
        else $error("found does not match red count");

    // Empty frame reports a zero centroid
    a_empty_centroid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> centroid_col == '0 && centroid_row == '0)
        else $error("centroid nonzero with no red pixels");

endmodule

bind red_pixel_mask_centroid rpmc_checker u_rpmc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .mask_white   (mask_white),
    .frame_end    (frame_end),
    .found        (found),
    .red_count    (red_count),
    .centroid_col (centroid_col),
    .centroid_row (centroid_row)
);
